@@ hdl/circular_double_ended_queue_assert.svh @@
// assertion macros used by the deque top level
`ifndef CIRCULAR_DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define CIRCULAR_DOUBLE_ENDED_QUEUE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define CDEQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define CDEQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/cdeq_pkg.sv @@
// ----------------------------------------------------------------------------
// cdeq_pkg
// Types and constants shared by the circular double-ended queue.
// ----------------------------------------------------------------------------
package cdeq_pkg;

   localparam int DEPTH  = 256;
   localparam int PTR_W  = $clog2(DEPTH);
   localparam int CAP_W  = 9;
   localparam int DATA_W = 32;
   localparam int FUNC_W = 3;
   localparam int RSP_W  = 80;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_PUSH_FRONT = 3'd0,
      FUNC_PUSH_BACK  = 3'd1,
      FUNC_POP_FRONT  = 3'd2,
      FUNC_POP_BACK   = 3'd3,
      FUNC_NONE       = 3'd4
   } func_type;

   // outcome of one operation, before the ring data is read
   typedef struct packed {
      logic              refused;
      logic              is_empty;
      logic              is_full;
      logic [CAP_W-1:0]  occupancy;
      logic              fwd_front;
      logic              fwd_back;
      logic [DATA_W-1:0] fwd_value;
   } status_type;

endpackage

@@ hdl/cdeq_ram.sv @@
// ----------------------------------------------------------------------------
// cdeq_ram
// Generic synchronous ram: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module cdeq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read ports, old data on a same-address write
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_a <= mem_ff[rd_addr_a];
         rd_data_b <= mem_ff[rd_addr_b];
      end
   end

endmodule

@@ hdl/cdeq_ctrl.sv @@
// ----------------------------------------------------------------------------
// cdeq_ctrl
// Ring pointers, element count and capacity; decodes each operation into a
// ring write, the two read addresses and the status of the result.
// ----------------------------------------------------------------------------
module cdeq_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wen,
   input  logic [cdeq_pkg::CAP_W-1:0]    csr_wdata,
   input  logic                          accept,
   input  cdeq_pkg::func_type            func,
   input  logic [cdeq_pkg::DATA_W-1:0]   push_value,
   output logic                          ram_we,
   output logic [cdeq_pkg::PTR_W-1:0]    ram_waddr,
   output logic [cdeq_pkg::DATA_W-1:0]   ram_wdata,
   output logic [cdeq_pkg::PTR_W-1:0]    rd_addr_front,
   output logic [cdeq_pkg::PTR_W-1:0]    rd_addr_back,
   output cdeq_pkg::status_type          status
);
   import cdeq_pkg::*;

   logic [CAP_W-1:0] cap_ff, cap_in;
   logic [PTR_W-1:0] cap_m1_ff, cap_m1_in;
   logic [PTR_W-1:0] front_ff, front_in;
   logic [PTR_W-1:0] back_ff, back_in;
   logic [CAP_W-1:0] count_ff, count_in;
   logic [CAP_W-1:0] cap_eff;
   logic             is_full_now;
   logic             is_empty_now;
   logic             refused;
   logic [PTR_W-1:0] op_front;
   logic [PTR_W-1:0] op_back;
   logic [CAP_W-1:0] op_count;

   function automatic logic [PTR_W-1:0] ring_inc(input logic [PTR_W-1:0] p,
                                                 input logic [PTR_W-1:0] last);
      return (p == last) ? '0 : p + PTR_W'(1);
   endfunction

   function automatic logic [PTR_W-1:0] ring_dec(input logic [PTR_W-1:0] p,
                                                 input logic [PTR_W-1:0] last);
      return (p == '0) ? last : p - PTR_W'(1);
   endfunction

   // capacity clamped to 1..DEPTH
   always_comb begin
      if (csr_wdata == '0) begin
         cap_eff = CAP_W'(1);
      end else if (32'(csr_wdata) > 32'(DEPTH)) begin
         cap_eff = CAP_W'(DEPTH);
      end else begin
         cap_eff = csr_wdata;
      end
   end

   assign is_full_now  = (count_ff >= cap_ff);
   assign is_empty_now = (count_ff == '0);

   // operation decode
   always_comb begin
      op_front  = front_ff;
      op_back   = back_ff;
      op_count  = count_ff;
      refused   = 1'b0;
      ram_we    = 1'b0;
      ram_waddr = front_ff;
      case (func)
         FUNC_PUSH_FRONT: begin
            if (is_full_now) begin
               refused = 1'b1;
            end else begin
               ram_we    = 1'b1;
               ram_waddr = front_ff;
               op_front  = ring_dec(front_ff, cap_m1_ff);
               op_count  = count_ff + CAP_W'(1);
            end
         end
         FUNC_PUSH_BACK: begin
            if (is_full_now) begin
               refused = 1'b1;
            end else begin
               ram_we    = 1'b1;
               ram_waddr = back_ff;
               op_back   = ring_inc(back_ff, cap_m1_ff);
               op_count  = count_ff + CAP_W'(1);
            end
         end
         FUNC_POP_FRONT: begin
            if (is_empty_now) begin
               refused = 1'b1;
            end else begin
               op_front = ring_inc(front_ff, cap_m1_ff);
               op_count = count_ff - CAP_W'(1);
            end
         end
         FUNC_POP_BACK: begin
            if (is_empty_now) begin
               refused = 1'b1;
            end else begin
               op_back  = ring_dec(back_ff, cap_m1_ff);
               op_count = count_ff - CAP_W'(1);
            end
         end
         default: begin
         end
      endcase
   end

   assign ram_wdata     = push_value;
   assign rd_addr_front = ring_inc(op_front, cap_m1_ff);
   assign rd_addr_back  = ring_dec(op_back, cap_m1_ff);

   // result status, with forwarding of a slot written in the same cycle
   always_comb begin
      status.refused   = refused;
      status.is_empty  = (op_count == '0);
      status.is_full   = (op_count == cap_ff);
      status.occupancy = op_count;
      status.fwd_front = ram_we && (rd_addr_front == ram_waddr);
      status.fwd_back  = ram_we && (rd_addr_back == ram_waddr);
      status.fwd_value = push_value;
   end

   // next state: a capacity write empties the queue
   always_comb begin
      cap_in    = cap_ff;
      cap_m1_in = cap_m1_ff;
      front_in  = front_ff;
      back_in   = back_ff;
      count_in  = count_ff;
      if (csr_wen) begin
         cap_in    = cap_eff;
         cap_m1_in = PTR_W'(cap_eff - CAP_W'(1));
         front_in  = '0;
         back_in   = (cap_eff == CAP_W'(1)) ? '0 : PTR_W'(1);
         count_in  = '0;
      end else if (accept) begin
         front_in = op_front;
         back_in  = op_back;
         count_in = op_count;
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff    <= CAP_W'(DEPTH);
         cap_m1_ff <= PTR_W'(DEPTH - 1);
         front_ff  <= '0;
         back_ff   <= PTR_W'(1);
         count_ff  <= '0;
      end else begin
         cap_ff    <= cap_in;
         cap_m1_ff <= cap_m1_in;
         front_ff  <= front_in;
         back_ff   <= back_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ hdl/circular_double_ended_queue.sv @@
// ----------------------------------------------------------------------------
// circular_double_ended_queue
// Ring-buffer deque with a programmable capacity, stream in and stream out.
// ----------------------------------------------------------------------------
// The deque takes one operation per cycle (push front, push back, pop front,
// pop back, none) and returns one status transfer for each: the operation is
// decoded and the ring write and both end reads are issued in the accept
// cycle, the ring memory registers its read data beside the pending status,
// and the result register is loaded from both once it is free. A slot
// written by the same operation is forwarded past the memory. Sustained
// rate is one operation per cycle while the result side keeps up. Writing
// csr_wdata empties the queue and sets the capacity (0 acts as 1, values above
// the ring depth act as the depth); write it only with no operation in flight.
module circular_double_ended_queue (
   input  logic                        clock,
   input  logic                        reset,
   // configuration
   input  logic                        csr_wen,
   input  logic [cdeq_pkg::CAP_W-1:0]  csr_wdata,
   // operation stream
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [cdeq_pkg::DATA_W-1:0] req_tdata,   // [31:0] push_value
   input  logic [cdeq_pkg::FUNC_W-1:0] req_tuser,   // [2:0] func
   // result stream
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // [0] refused, [1] is_empty, [2] is_full, [11:3] occupancy,
   // [43:12] front_value, [75:44] back_value, [79:76] zero
   output logic [cdeq_pkg::RSP_W-1:0]  rsp_tdata
);
   import cdeq_pkg::*;

`include "circular_double_ended_queue_assert.svh"

   logic              req_accept;
   logic              out_free;
   logic              pend_move;
   logic              ram_we;
   logic [PTR_W-1:0]  ram_waddr;
   logic [DATA_W-1:0] ram_wdata;
   logic [PTR_W-1:0]  rd_addr_front;
   logic [PTR_W-1:0]  rd_addr_back;
   logic [DATA_W-1:0] rd_data_front;
   logic [DATA_W-1:0] rd_data_back;
   status_type        op_status;
   logic              pend_valid_ff, pend_valid_in;
   status_type        pend_ff;
   logic              out_valid_ff, out_valid_in;
   logic [RSP_W-1:0]  out_data_ff;
   logic [DATA_W-1:0] front_value;
   logic [DATA_W-1:0] back_value;

   // handshake: result register frees the pending stage
   assign out_free   = !out_valid_ff || rsp_tready;
   assign pend_move  = pend_valid_ff && out_free;
   assign req_tready = !pend_valid_ff || out_free;
   assign req_accept = req_tvalid && req_tready;

   // pointers, count and operation decode
   cdeq_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .csr_wen       (csr_wen),
      .csr_wdata     (csr_wdata),
      .accept        (req_accept),
      .func          (func_type'(req_tuser)),
      .push_value    (req_tdata),
      .ram_we        (ram_we),
      .ram_waddr     (ram_waddr),
      .ram_wdata     (ram_wdata),
      .rd_addr_front (rd_addr_front),
      .rd_addr_back  (rd_addr_back),
      .status        (op_status)
   );

   // ring storage
   cdeq_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_ring (
      .clock     (clock),
      .wr_en     (ram_we && req_accept),
      .wr_addr   (ram_waddr),
      .wr_data   (ram_wdata),
      .rd_en     (req_accept),
      .rd_addr_a (rd_addr_front),
      .rd_addr_b (rd_addr_back),
      .rd_data_a (rd_data_front),
      .rd_data_b (rd_data_back)
   );

   // end values: zero when empty, forwarded when written by the same transfer
   always_comb begin
      if (pend_ff.is_empty) begin
         front_value = '0;
         back_value  = '0;
      end else begin
         front_value = pend_ff.fwd_front ? pend_ff.fwd_value : rd_data_front;
         back_value  = pend_ff.fwd_back  ? pend_ff.fwd_value : rd_data_back;
      end
   end

   // stage control
   always_comb begin
      pend_valid_in = pend_valid_ff;
      if (req_accept) begin
         pend_valid_in = 1'b1;
      end else if (pend_move) begin
         pend_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (pend_move) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         pend_ff <= op_status;
      end
      if (pend_move) begin
         out_data_ff <= {4'b0000, back_value, front_value, pend_ff.occupancy,
                         pend_ff.is_full, pend_ff.is_empty, pend_ff.refused};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   // checks
   `CDEQ_ASSERT_NEXT(a_accept_pends, clock, reset, req_accept, pend_valid_ff,
      "accepted operation did not reach the pending stage")
   `CDEQ_ASSERT_NOW(a_stall_blocks, clock, reset, pend_valid_ff && !out_free,
      !req_tready, "operation accepted while the pending stage is blocked")
   `CDEQ_ASSERT_NOW(a_empty_not_full, clock, reset, rsp_tvalid,
      !(rsp_tdata[1] && rsp_tdata[2]), "result reports both empty and full")
   `CDEQ_ASSERT_NOW(a_empty_zero, clock, reset, rsp_tvalid && rsp_tdata[1],
      rsp_tdata[75:12] == '0 && rsp_tdata[11:3] == '0,
      "empty result carries a count or end values")

endmodule
